>>> sv/vn2d_pkg.sv
// ----------------------------------------------------------------------------
// vn2d_pkg
// Shared constants for the 2D value noise pipeline: lattice hash terms,
// internal widths and pipeline latency.
// ----------------------------------------------------------------------------
package vn2d_pkg;

	// lattice hash terms, all arithmetic wraps modulo 2^32
	localparam logic [31:0] HASH_Y_MUL = 32'd57;
	localparam int          HASH_SHIFT = 13;
	localparam logic [31:0] HASH_C1    = 32'd15731;
	localparam logic [31:0] HASH_C2    = 32'd789221;
	localparam logic [31:0] HASH_C3    = 32'd1376312589;
	localparam logic [31:0] HASH_MASK  = 32'h7fff_ffff;
	localparam logic [31:0] ONE_Q30    = 32'h4000_0000;

	// internal value width: holds bicubic overshoot of Q2.30 values
	localparam int VAL_W   = 40;
	localparam int OUT_W   = 32;
	// Q2.30 to Q6.26
	localparam int OUT_SHR = 4;

	// stage counts: input register, hash, row cubic, column cubic, output
	localparam int HASH_LAT  = 4;
	localparam int CUBIC_LAT = 4;
	localparam int PIPE_LAT  = 1 + HASH_LAT + CUBIC_LAT + CUBIC_LAT + 1;

endpackage

>>> sv/vn2d_hash.sv
// ----------------------------------------------------------------------------
// vn2d_hash
// Four-stage lattice hash: integer point to a Q2.30 value in (-1, 1].
// ----------------------------------------------------------------------------
module vn2d_hash (
	input  logic        clk,
	input  logic [31:0] xi,
	input  logic [31:0] yi,
	output logic [31:0] val
);
	import vn2d_pkg::*;

	logic [31:0] n_lin;
	logic [31:0] n_s1;
	logic [31:0] n_s2, sq_s2;
	logic [31:0] n_s3, a_s3;
	logic [31:0] val_s4;
	logic [31:0] b_full;

	// linear combination and shift-xor
	always_comb begin
		n_lin = xi + yi * HASH_Y_MUL;
	end

	always_ff @(posedge clk) begin
		n_s1 <= (n_lin << HASH_SHIFT) ^ n_lin;
	end

	// square
	always_ff @(posedge clk) begin
		n_s2  <= n_s1;
		sq_s2 <= n_s1 * n_s1;
	end

	// inner polynomial term
	always_ff @(posedge clk) begin
		n_s3 <= n_s2;
		a_s3 <= sq_s2 * HASH_C1 + HASH_C2;
	end

	// outer term, mask to 31 bits and map to Q2.30
	always_comb begin
		b_full = n_s3 * a_s3 + HASH_C3;
	end

	always_ff @(posedge clk) begin
		val_s4 <= ONE_Q30 - (b_full & HASH_MASK);
	end

	assign val = val_s4;

endmodule

>>> sv/vn2d_cubic.sv
// ----------------------------------------------------------------------------
// vn2d_cubic
// Four-stage four-point cubic in Horner form; in linear mode it reduces to
// a two-point blend between v1 and v2.
// ----------------------------------------------------------------------------
module vn2d_cubic #(
	parameter int W  = 40,
	parameter int FB = 16
) (
	input  logic                clk,
	input  logic                lin,
	input  logic signed [W-1:0] v0,
	input  logic signed [W-1:0] v1,
	input  logic signed [W-1:0] v2,
	input  logic signed [W-1:0] v3,
	input  logic [FB-1:0]       t,
	output logic signed [W-1:0] f
);
	localparam int PW = W + FB + 1;

	logic signed [W-1:0] p_s1, q_s1, r_s1, s_s1;
	logic [FB-1:0]       t_s1, t_s2, t_s3;
	logic signed [W-1:0] acc_s2, r_s2, s_s2;
	logic signed [W-1:0] acc_s3, s_s3;
	logic signed [W-1:0] acc_s4;
	logic signed [W-1:0] p_c, d01;

	// acc * t / 2^FB, rounded to nearest with ties upward
	function automatic logic signed [W-1:0] mul_rnd(input logic signed [W-1:0] a,
			input logic [FB-1:0] tt);
		logic signed [PW-1:0] pr;
		pr = PW'(a) * PW'($signed({1'b0, tt}));
		pr = pr + (PW'(1) <<< (FB - 1));
		return W'(pr >>> FB);
	endfunction

	// coefficients
	always_comb begin
		d01 = v0 - v1;
		p_c = (v3 - v2) - d01;
	end

	always_ff @(posedge clk) begin
		if (lin) begin
			p_s1 <= '0;
			q_s1 <= '0;
			r_s1 <= v2 - v1;
		end else begin
			p_s1 <= p_c;
			q_s1 <= d01 - p_c;
			r_s1 <= v2 - v0;
		end
		s_s1 <= v1;
		t_s1 <= t;
	end

	// Horner steps
	always_ff @(posedge clk) begin
		acc_s2 <= mul_rnd(p_s1, t_s1) + q_s1;
		r_s2   <= r_s1;
		s_s2   <= s_s1;
		t_s2   <= t_s1;
	end

	always_ff @(posedge clk) begin
		acc_s3 <= mul_rnd(acc_s2, t_s2) + r_s2;
		s_s3   <= s_s2;
		t_s3   <= t_s2;
	end

	always_ff @(posedge clk) begin
		acc_s4 <= mul_rnd(acc_s3, t_s3) + s_s3;
	end

	assign f = acc_s4;

endmodule

>>> sv/value_noise_2d_interpolated.sv
// Throughput: one sample per cycle; busy stays low, the pipeline never stalls.
// The rate is set by the fully pipelined hash and cubic units, 16 hashes in parallel.
// Reset (arst_n low) clears the valid chain and sets the mode register to bilinear.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// value_noise_2d_interpolated
// 2D value noise with bilinear or bicubic interpolation, Q6.26 saturated out.
// ----------------------------------------------------------------------------
module value_noise_2d_interpolated #(
	parameter int COORD_INT_BITS = 16,
	parameter int FRAC_BITS      = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [COORD_INT_BITS-1:0] x_int,
	input  logic [FRAC_BITS-1:0]      x_frac,
	input  logic signed [COORD_INT_BITS-1:0] y_int,
	input  logic [FRAC_BITS-1:0]      y_frac,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      interp_mode,
	output logic                      result_valid,
	output logic signed [vn2d_pkg::OUT_W-1:0] noise_value,
	output logic                      saturated
);
	import vn2d_pkg::*;

	localparam int TX_DLY = 1 + HASH_LAT;
	localparam int TY_DLY = TX_DLY + CUBIC_LAT;

	logic                 mode_q;
	logic [PIPE_LAT-1:0]  vld_q;
	logic [31:0]          xi_s1, yi_s1;
	logic [FRAC_BITS-1:0] tx_dly_q [TX_DLY];
	logic [FRAC_BITS-1:0] ty_dly_q [TY_DLY];
	logic [31:0]          grid [4][4];
	logic signed [VAL_W-1:0] row_val [4];
	logic signed [VAL_W-1:0] col_val;
	logic signed [VAL_W-1:0] rs;
	logic signed [OUT_W-1:0] noise_q;
	logic                 sat_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= interp_mode;
		end
	end

	// valid chain alongside the data stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[PIPE_LAT-2:0], start && !busy};
		end
	end

	// input register, coordinates widened to 32 bits
	always_ff @(posedge clk) begin
		xi_s1 <= 32'($signed(x_int));
		yi_s1 <= 32'($signed(y_int));
	end

	// fraction delay lines to the row and column cubics
	always_ff @(posedge clk) begin
		tx_dly_q[0] <= x_frac;
		ty_dly_q[0] <= y_frac;
		for (int i = 1; i < TX_DLY; i++) begin
			tx_dly_q[i] <= tx_dly_q[i-1];
		end
		for (int i = 1; i < TY_DLY; i++) begin
			ty_dly_q[i] <= ty_dly_q[i-1];
		end
	end

	// 4x4 lattice hashes: rows y-1..y+2, columns x-1..x+2
	for (genvar j = 0; j < 4; j++) begin : g_row
		for (genvar i = 0; i < 4; i++) begin : g_col
			vn2d_hash u_hash (
				.clk (clk),
				.xi  (xi_s1 + 32'(i) - 32'd1),
				.yi  (yi_s1 + 32'(j) - 32'd1),
				.val (grid[j][i])
			);
		end

		vn2d_cubic #(.W(VAL_W), .FB(FRAC_BITS)) u_row (
			.clk (clk),
			.lin (!mode_q),
			.v0  (VAL_W'($signed(grid[j][0]))),
			.v1  (VAL_W'($signed(grid[j][1]))),
			.v2  (VAL_W'($signed(grid[j][2]))),
			.v3  (VAL_W'($signed(grid[j][3]))),
			.t   (tx_dly_q[TX_DLY-1]),
			.f   (row_val[j])
		);
	end

	// column pass over the four row results
	vn2d_cubic #(.W(VAL_W), .FB(FRAC_BITS)) u_col (
		.clk (clk),
		.lin (!mode_q),
		.v0  (row_val[0]),
		.v1  (row_val[1]),
		.v2  (row_val[2]),
		.v3  (row_val[3]),
		.t   (ty_dly_q[TY_DLY-1]),
		.f   (col_val)
	);

	// Q2.30 to Q6.26 with rounding, then clamp
	always_comb begin
		rs = (col_val + (VAL_W'(1) <<< (OUT_SHR - 1))) >>> OUT_SHR;
	end

	always_ff @(posedge clk) begin
		if (rs > VAL_W'(33'sh0_7fff_ffff)) begin
			noise_q <= {1'b0, {(OUT_W-1){1'b1}}};
			sat_q   <= 1'b1;
		end else if (rs < -(VAL_W'(33'sh0_8000_0000))) begin
			noise_q <= {1'b1, {(OUT_W-1){1'b0}}};
			sat_q   <= 1'b1;
		end else begin
			noise_q <= OUT_W'(rs);
			sat_q   <= 1'b0;
		end
	end

	assign result_valid = vld_q[PIPE_LAT-1];
	assign noise_value  = noise_q;
	assign saturated    = sat_q;

endmodule

>>> sv/vn2d_checker.sv
// ----------------------------------------------------------------------------
// vn2d_checker
// Port-level checks on the noise pipeline: fixed latency and clamp codes.
// ----------------------------------------------------------------------------
module vn2d_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        result_valid,
	input logic [31:0] noise_value,
	input logic        saturated
);
	import vn2d_pkg::*;

	// every transfer gives a strobe after the fixed latency
	a_lat_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_LAT result_valid)
		else $error("missing result strobe");

	// no strobe without a transfer
	a_lat_miss: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##PIPE_LAT !result_valid)
		else $error("spurious result strobe");

	// a clipped result is one of the two limits
	a_sat_code: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && saturated) |->
			(noise_value == 32'h7fff_ffff || noise_value == 32'h8000_0000))
		else $error("saturated result off the limits");

endmodule

bind value_noise_2d_interpolated vn2d_checker u_vn2d_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.noise_value  (noise_value),
	.saturated    (saturated)
);
